@@ src/per_key_matrix_debouncer_top_defines.svh @@
// Assertion macros for the per-key matrix debouncer.
// Included by the top level; no other dependencies.
`ifndef PER_KEY_MATRIX_DEBOUNCER_TOP_DEFINES_SVH
`define PER_KEY_MATRIX_DEBOUNCER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PKMD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define PKMD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) else $error(msg);
`else
`define PKMD_ASSERT(lbl, clk, rstn, prop, msg)
`define PKMD_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

@@ src/pkmd_pkg.sv @@
// Shared types and constants for the per-key matrix debouncer.
// No dependencies.
`default_nettype none
package pkmd_pkg;

  localparam int ROW_W   = 3;
  localparam int DATA_W  = 16;
  localparam int CNT_W   = 8;
  localparam int CFG_I_W = 2;

  typedef logic [CFG_I_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PRESS_IDX   = 2'd0;
  localparam cfg_idx_t CFG_RELEASE_IDX = 2'd1;

  localparam logic [CNT_W-1:0] PRESS_RST   = 8'd2;
  localparam logic [CNT_W-1:0] RELEASE_RST = 8'd3;

  // per-lane control, common to all columns of one transfer
  typedef struct packed {
    logic             we;
    logic             tick;
    logic [CNT_W-1:0] press_checks;
    logic [CNT_W-1:0] rel_checks;
  } lane_ctl_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row_out_index;
    logic [DATA_W-1:0] debounced_row;
  } res_t;

  typedef struct packed {
    logic out_v;
    logic skid_v;
  } buf_stat_t;

endpackage
`default_nettype wire

@@ src/pkmd_if.sv @@
// Valid/ready channel interfaces for scan rows and debounced rows.
// Depends on pkmd_pkg.
`default_nettype none
interface pkmd_in_if;
  logic                       valid;
  logic                       ready;
  logic [pkmd_pkg::ROW_W-1:0]  row_index;
  logic [pkmd_pkg::DATA_W-1:0] raw_row;
  logic                       tick_elapsed;

  modport source (output valid, row_index, raw_row, tick_elapsed, input ready);
  modport sink   (input valid, row_index, raw_row, tick_elapsed, output ready);
endinterface

interface pkmd_out_if;
  logic                       valid;
  logic                       ready;
  logic [pkmd_pkg::ROW_W-1:0]  row_out_index;
  logic [pkmd_pkg::DATA_W-1:0] debounced_row;

  modport source (output valid, row_out_index, debounced_row, input ready);
  modport sink   (input valid, row_out_index, debounced_row, output ready);
endinterface
`default_nettype wire

@@ src/pkmd_lane.sv @@
// One column lane: per-row previous raw bit, debounced bit and countdown.
// Depends on pkmd_pkg.
`default_nettype none
module pkmd_lane #(
  parameter int ROWS = 8,
  parameter int RW   = 3
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pkmd_pkg::lane_ctl_t ctl,
  input  wire logic [RW-1:0]      rsel,
  input  wire logic               raw_bit,
  output logic                    stable_bit
);
  import pkmd_pkg::*;

  logic [ROWS-1:0]  prev_r;
  logic [ROWS-1:0]  stable_r;
  logic [CNT_W-1:0] cnt_r [ROWS];

  logic [CNT_W-1:0] cnt_cur, cnt_dec, cnt_load, cnt_nxt;
  logic             ob, st_nxt;

  always_comb begin
    cnt_cur  = cnt_r[rsel];
    ob       = prev_r[rsel];
    cnt_dec  = cnt_cur - 1'b1;
    cnt_load = raw_bit ? ctl.press_checks : ctl.rel_checks;
    cnt_nxt  = cnt_cur;
    st_nxt   = stable_r[rsel];
    if (cnt_cur != '0) begin
      if (ctl.tick) begin
        if (raw_bit == ob) begin
          cnt_nxt = cnt_dec;
          if (cnt_dec == '0) st_nxt = raw_bit;
        end else begin
          cnt_nxt = cnt_load;
        end
      end
    end else if (raw_bit != ob) begin
      cnt_nxt = cnt_load;
    end
  end

  assign stable_bit = st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      stable_r <= '0;
      for (int r = 0; r < ROWS; r++) cnt_r[r] <= '0;
    end else if (ctl.we) begin
      prev_r[rsel]   <= raw_bit;
      stable_r[rsel] <= st_nxt;
      cnt_r[rsel]    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/pkmd_merge.sv @@
// Merges lane bits into the result row and buffers it (output register + skid).
// Depends on pkmd_pkg.
`default_nettype none
module pkmd_merge #(
  parameter int COLS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        accept,
  input  wire logic                        row_ok,
  input  wire logic [pkmd_pkg::ROW_W-1:0]  row_index,
  input  wire logic [COLS-1:0]             lane_bits,
  output logic                             in_ready,
  output pkmd_pkg::buf_stat_t              stat,
  output pkmd_pkg::res_t                   out_res,
  output logic                             out_valid,
  input  wire logic                        out_ready
);
  import pkmd_pkg::*;

  logic [DATA_W-1:0] row_bits;
  res_t              res_new;
  res_t              out_r, skid_r;
  logic              out_v_r, skid_v_r;

  for (genvar i = 0; i < DATA_W; i++) begin : g_pack
    if (i < COLS) begin : g_col
      assign row_bits[i] = row_ok & lane_bits[i];
    end else begin : g_pad
      assign row_bits[i] = 1'b0;
    end
  end

  assign res_new.row_out_index = row_index;
  assign res_new.debounced_row = row_bits;

  assign in_ready  = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign stat      = '{out_v: out_v_r, skid_v: skid_v_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      if (skid_v_r) out_r <= skid_r;
      else if (accept) out_r <= res_new;
    end else if (accept) begin
      skid_r <= res_new;
    end
  end

endmodule
`default_nettype wire

@@ src/per_key_matrix_debouncer_top.sv @@
// Channel    | Dir | Fields                                   | Transfer when
// in_if      | in  | row_index, raw_row, tick_elapsed         | valid && ready
// out_if     | out | row_out_index, debounced_row             | valid && ready
// cfg_*      | in  | cfg_index, cfg_data (press/release)      | cfg_we
//
// One row per cycle while ready is high: all column lanes update their key state for the
// addressed row (when it is below ROWS) in the cycle of the transfer; the result is
// registered into the output register, or into the skid when the output is stalled.
// Reset (synchronous, rst_n low) clears all key state at once, no sweep.
// A stalled output fills a one-entry skid; ready drops only when it is full.
// Depends on pkmd_pkg, pkmd_if, pkmd_lane, pkmd_merge and the defines header.
`default_nettype none
`include "per_key_matrix_debouncer_top_defines.svh"
module per_key_matrix_debouncer_top #(
  parameter int ROWS = 8,
  parameter int COLS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  pkmd_in_if.sink                          in_if,
  pkmd_out_if.source                       out_if,
  input  wire logic                        cfg_we,
  input  wire logic [pkmd_pkg::CFG_I_W-1:0] cfg_index,
  input  wire logic [pkmd_pkg::CNT_W-1:0]  cfg_data
);
  import pkmd_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [CNT_W-1:0] press_r, rel_r;
  logic             accept, row_ok, buf_ready;
  logic [RW-1:0]    rsel;
  logic [COLS-1:0]  lane_bits;
  lane_ctl_t        ctl;
  buf_stat_t        stat;
  res_t             out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_r <= PRESS_RST;
      rel_r   <= RELEASE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRESS_IDX:   press_r <= cfg_data;
        CFG_RELEASE_IDX: rel_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = in_if.valid && buf_ready;
  assign row_ok = (32'(in_if.row_index) < ROWS);
  assign rsel   = RW'(in_if.row_index);

  assign ctl.we           = accept && row_ok;
  assign ctl.tick         = in_if.tick_elapsed;
  assign ctl.press_checks = press_r;
  assign ctl.rel_checks   = rel_r;

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    logic raw_bit;
    if (c < DATA_W) begin : g_in
      assign raw_bit = in_if.raw_row[c];
    end else begin : g_zero
      assign raw_bit = 1'b0;
    end
    pkmd_lane #(.ROWS(ROWS), .RW(RW)) u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .rsel      (rsel),
      .raw_bit   (raw_bit),
      .stable_bit(lane_bits[c])
    );
  end

  pkmd_merge #(.COLS(COLS)) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .row_ok   (row_ok),
    .row_index(in_if.row_index),
    .lane_bits(lane_bits),
    .in_ready (buf_ready),
    .stat     (stat),
    .out_res  (out_res),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready)
  );

  assign in_if.ready          = buf_ready;
  assign out_if.row_out_index = out_res.row_out_index;
  assign out_if.debounced_row = out_res.debounced_row;

  `PKMD_ASSERT(a_skid_behind_out, clk, rst_n, !(stat.skid_v && !stat.out_v), "skid full while output empty")
  `PKMD_ASSERT_NEXT(a_stall_fills_skid, clk, rst_n, accept && stat.out_v && !out_if.ready, stat.skid_v, "stalled transfer not held in skid")
  `PKMD_ASSERT_NEXT(a_press_write, clk, rst_n, cfg_we && (cfg_index == CFG_PRESS_IDX), press_r == $past(cfg_data), "press count write lost")

endmodule
`default_nettype wire
